// File: hw/rtl/crlr_pkg.sv
package crlr_pkg;

  localparam int COLUMNS_DEF     = 256;
  localparam int BREAKPOINTS_DEF = 16;

  // Output queue that decouples the render pipeline from the result channel.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = 2;
  localparam int OQ_CNT_W = 3;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  typedef struct packed {
    logic        we;
    logic [15:0] color;
    logic [7:0]  column;
  } result_t;

endpackage

// File: hw/rtl/crlr_oq.sv
module crlr_oq (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push_valid,
  input  crlr_pkg::result_t                push_data,
  output logic                             pop_valid,
  input  logic                             pop_ready,
  output crlr_pkg::result_t                pop_data,
  output logic [crlr_pkg::OQ_CNT_W-1:0]    count
);

  crlr_pkg::result_t                 entries_r [crlr_pkg::OQ_DEPTH];
  logic [crlr_pkg::OQ_PTR_W-1:0]     wr_ptr_r;
  logic [crlr_pkg::OQ_PTR_W-1:0]     rd_ptr_r;
  logic [crlr_pkg::OQ_CNT_W-1:0]     cnt_r;
  logic [crlr_pkg::OQ_CNT_W-1:0]     cnt_nxt;
  logic                              pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = entries_r[rd_ptr_r];
  assign count     = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_valid && !pop) begin
      cnt_nxt = cnt_r + crlr_pkg::OQ_CNT_W'(1);
    end else if (!push_valid && pop) begin
      cnt_nxt = cnt_r - crlr_pkg::OQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_valid) begin
        wr_ptr_r <= wr_ptr_r + crlr_pkg::OQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + crlr_pkg::OQ_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hw/rtl/column_run_length_renderer_core.sv
// Flow: a render request accepted on the input passes a registered cursor read, a
// registered breakpoint read, the update and a queue write before its pixel shows.
// Throughput: one request per cycle while in_tready is high; cursor hazards are forwarded.
// Reset: synchronous, active low. After reset the cursor memory is cleared one column
// per cycle, all COLUMNS of them, with in_tready low; breakpoint memories are not cleared.
module column_run_length_renderer_core #(
  parameter int COLUMNS     = crlr_pkg::COLUMNS_DEF,
  parameter int BREAKPOINTS = crlr_pkg::BREAKPOINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // column[7:0], slot[11:8], start_line[19:12], color_value[35:20], line[43:36], zero pad
  input  logic [47:0] in_tdata,
  // operation[0], repeat_line[1]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // pixel_column[7:0], pixel_color[23:8]
  output logic [23:0] out_tdata,
  // write_enable[0]
  output logic [0:0]  out_tuser
);

  localparam int CIDX_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int SLOT_W  = $clog2(BREAKPOINTS);
  localparam int CUR_W   = $clog2(2 * BREAKPOINTS);
  localparam int ENTRIES = COLUMNS * BREAKPOINTS;
  localparam int AW      = $clog2(ENTRIES);
  localparam int USE_W   = crlr_pkg::OQ_CNT_W + 1;

  logic              in_op;
  logic              in_rep;
  logic [7:0]        in_column;
  logic [3:0]        in_slot;
  logic [7:0]        in_start;
  logic [15:0]       in_color;
  logic [7:0]        in_line;
  logic [CIDX_W-1:0] in_cidx;
  logic              accept;
  logic              col_ok;
  logic              slot_ok;
  logic              load_we;
  logic              render_go;
  logic [AW-1:0]     load_addr;

  assign in_op     = in_tuser[0];
  assign in_rep    = in_tuser[1];
  assign in_column = in_tdata[7:0];
  assign in_slot   = in_tdata[11:8];
  assign in_start  = in_tdata[19:12];
  assign in_color  = in_tdata[35:20];
  assign in_line   = in_tdata[43:36];
  assign in_cidx   = CIDX_W'(in_column);

  assign accept    = in_tvalid && in_tready;
  assign col_ok    = 32'(in_column) < COLUMNS;
  assign slot_ok   = 32'(in_slot) < BREAKPOINTS;
  assign load_we   = accept && col_ok && (in_op == crlr_pkg::OP_LOAD) && slot_ok;
  assign render_go = accept && col_ok && (in_op == crlr_pkg::OP_RENDER) && !in_rep;
  assign load_addr = AW'(in_cidx) * AW'(BREAKPOINTS) + AW'(in_slot);

  // Cursor memory with clearing pass.
  logic [CUR_W-1:0]  cur_mem [COLUMNS];
  logic [CUR_W-1:0]  cur_rd_r;
  logic              cur_we;
  logic [CIDX_W-1:0] cur_waddr;
  logic [CUR_W-1:0]  cur_wdata;
  logic              clr_r;
  logic [CIDX_W-1:0] clr_idx_r;

  // Pipeline registers.
  logic              s1_v_r;
  logic [CIDX_W-1:0] s1_cidx_r;
  logic [7:0]        s1_col_r;
  logic [7:0]        s1_line_r;
  logic              s2_v_r;
  logic [CIDX_W-1:0] s2_cidx_r;
  logic [7:0]        s2_col_r;
  logic [7:0]        s2_line_r;
  logic [CUR_W-1:0]  s2_cur_r;
  logic              s2_can_r;
  logic [CUR_W-1:0]  s2_cur_nxt;
  logic              wb_v_r;
  logic [CIDX_W-1:0] wb_cidx_r;
  logic [CUR_W-1:0]  wb_cur_r;

  // Breakpoint memories.
  logic [7:0]        line_mem  [ENTRIES];
  logic [15:0]       color_mem [ENTRIES];
  logic [7:0]        bl_rd_r;
  logic [15:0]       ch_rd_r;
  logic [15:0]       cl_rd_r;

  // Stage 1: forwarded cursor, breakpoint indexes.
  logic [CUR_W-1:0]  s1_cur;
  logic [SLOT_W-1:0] s1_k;
  logic              s1_can;
  logic [SLOT_W-1:0] s1_lo;
  logic [SLOT_W-1:0] s1_hi;
  logic [AW-1:0]     s1_base;
  logic [AW-1:0]     addr_lo;
  logic [AW-1:0]     addr_hi;

  always_comb begin
    if (s2_v_r && (s2_cidx_r == s1_cidx_r)) begin
      s1_cur = s2_cur_nxt;
    end else if (wb_v_r && (wb_cidx_r == s1_cidx_r)) begin
      // Covers a write that landed in the same cycle as this item's read.
      s1_cur = wb_cur_r;
    end else begin
      s1_cur = cur_rd_r;
    end
    s1_k = s1_cur[CUR_W-1:1];
    if (32'(s1_k) > BREAKPOINTS - 1) begin
      s1_k = SLOT_W'(BREAKPOINTS - 1);
    end
    s1_can = 32'(s1_k) < BREAKPOINTS - 1;
    if ((s1_line_r == 8'd0) || (s1_line_r == 8'd1)) begin
      s1_lo = '0;
      s1_hi = SLOT_W'(1);
    end else begin
      s1_lo = s1_k;
      s1_hi = s1_can ? (s1_k + SLOT_W'(1)) : s1_k;
    end
  end

  assign s1_base = AW'(s1_cidx_r) * AW'(BREAKPOINTS);
  assign addr_lo = s1_base + AW'(s1_lo);
  assign addr_hi = s1_base + AW'(s1_hi);

  always_ff @(posedge clk) begin
    if (load_we) begin
      line_mem[load_addr] <= in_start;
    end
    if (s1_v_r) begin
      bl_rd_r <= line_mem[addr_hi];
    end
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      color_mem[load_addr] <= in_color;
    end
    if (s1_v_r) begin
      ch_rd_r <= color_mem[addr_hi];
      cl_rd_r <= color_mem[addr_lo];
    end
  end

  // Stage 2: advance decision and cursor update.
  crlr_pkg::result_t s2_res;
  logic              s2_ge;
  logic              s2_adv;

  always_comb begin
    s2_ge        = s2_line_r >= bl_rd_r;
    s2_adv       = s2_can_r && s2_ge;
    s2_res.column = s2_col_r;
    s2_res.we     = 1'b1;
    s2_res.color  = cl_rd_r;
    s2_cur_nxt    = s2_cur_r;
    if (s2_line_r == 8'd0) begin
      s2_cur_nxt = '0;
    end else if (s2_line_r == 8'd1) begin
      if (s2_ge) begin
        s2_res.color = ch_rd_r;
        s2_cur_nxt   = CUR_W'(3);
      end
    end else if (s2_cur_r[0]) begin
      if (s2_adv) begin
        s2_res.color = ch_rd_r;
        s2_cur_nxt   = s2_cur_r + CUR_W'(2);
      end else begin
        s2_cur_nxt   = s2_cur_r - CUR_W'(1);
      end
    end else begin
      if (s2_adv) begin
        s2_res.color = ch_rd_r;
        s2_cur_nxt   = s2_cur_r + CUR_W'(3);
      end else begin
        s2_res.we    = 1'b0;
        s2_res.color = '0;
      end
    end
  end

  assign cur_we    = clr_r || s2_v_r;
  assign cur_waddr = clr_r ? clr_idx_r : s2_cidx_r;
  assign cur_wdata = clr_r ? '0 : s2_cur_nxt;

  always_ff @(posedge clk) begin
    if (cur_we) begin
      cur_mem[cur_waddr] <= cur_wdata;
    end
    if (render_go) begin
      cur_rd_r <= cur_mem[in_cidx];
    end
  end

  always_ff @(posedge clk) begin
    if (render_go) begin
      s1_cidx_r <= in_cidx;
      s1_col_r  <= in_column;
      s1_line_r <= in_line;
    end
    if (s1_v_r) begin
      s2_cidx_r <= s1_cidx_r;
      s2_col_r  <= s1_col_r;
      s2_line_r <= s1_line_r;
      s2_cur_r  <= s1_cur;
      s2_can_r  <= s1_can;
    end
    if (s2_v_r) begin
      wb_cidx_r <= s2_cidx_r;
      wb_cur_r  <= s2_cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      wb_v_r    <= 1'b0;
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
    end else begin
      s1_v_r <= render_go;
      s2_v_r <= s1_v_r;
      wb_v_r <= s2_v_r;
      if (clr_r) begin
        clr_idx_r <= clr_idx_r + CIDX_W'(1);
        if (clr_idx_r == CIDX_W'(COLUMNS - 1)) begin
          clr_r <= 1'b0;
        end
      end
    end
  end

  // Output queue; requests are taken only while every item in flight has a place in it.
  crlr_pkg::result_t               oq_data;
  logic [crlr_pkg::OQ_CNT_W-1:0]   oq_cnt;
  logic [USE_W-1:0]                used;

  crlr_oq u_oq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (s2_v_r),
    .push_data  (s2_res),
    .pop_valid  (out_tvalid),
    .pop_ready  (out_tready),
    .pop_data   (oq_data),
    .count      (oq_cnt)
  );

  assign used      = USE_W'(oq_cnt) + USE_W'(s1_v_r) + USE_W'(s2_v_r);
  assign in_tready = !clr_r && (used < USE_W'(crlr_pkg::OQ_DEPTH));
  assign out_tdata = {oq_data.color, oq_data.column};
  assign out_tuser = oq_data.we;

endmodule

// File: hw/rtl/crlr_props.sv
module crlr_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // A pending result is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // The cursor clearing pass holds off requests right after reset.
  a_clear_blocks: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("request taken during cursor clearing");

  // A skipped write always carries a zero color.
  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[23:8] == 16'd0)
    else $error("skipped write with nonzero color");

endmodule

bind column_run_length_renderer_core crlr_props u_props (.*);
